@@ src/sbcr_pkg.sv @@
// Shared widths, codes, payload types and helpers of the swept box collision block.
`default_nettype none

package sbcr_pkg;

  // Fixed formats
  localparam int CW     = 32;        // coordinate and velocity width
  localparam int FB     = 16;        // fraction bits of coordinates
  localparam int TB     = 16;        // fraction bits of contact time
  localparam int DTW    = 21;        // time step width
  localparam int BW     = 17;        // restitution width
  localparam int MW     = CW - 1;    // mass and box size width
  localparam int DT_RESET = 1092;

  // Derived internal widths
  localparam int RV_W   = CW + 1;              // relative velocity
  localparam int MV_W   = RV_W + DTW + 1 - FB; // relative move
  localparam int OM_W   = CW + DTW + 1 - FB;   // single body move
  localparam int CE_W   = CW + 1;              // edge line and edge ends
  localparam int REM_W  = MV_W + 1;            // edge divider remainder
  localparam int MREM_W = MW + 2;              // mass divider remainder
  localparam int EW     = 2 * BW - TB;         // combined restitution
  localparam int KW     = EW + 1;              // one plus restitution
  localparam int NV_W   = RV_W + 1;            // closing speed
  localparam int PP_W   = MV_W + TB + 1 - TB;  // crossing point
  localparam int D_W    = NV_W + KW + 1 - TB;  // impulse magnitude
  localparam int DV_W   = D_W + 2;             // velocity change
  localparam int SAT_W  = CW + 10;             // pre-saturation width

  localparam logic [TB:0] TIME_ONE = (TB + 1)'(1) << TB;

  // Register index of the time step
  localparam logic REG_TIME_STEP = 1'b0;

  // Edge codes
  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_TOP    = 2'd1;
  localparam logic [1:0] SIDE_RIGHT  = 2'd2;
  localparam logic [1:0] SIDE_BOTTOM = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] rel_min_x;
    logic signed [CW-1:0] rel_min_y;
    logic        [MW-1:0] rel_width;
    logic        [MW-1:0] rel_height;
    logic signed [CW-1:0] own_vel_x;
    logic signed [CW-1:0] own_vel_y;
    logic signed [CW-1:0] peer_vel_x;
    logic signed [CW-1:0] peer_vel_y;
    logic        [MW-1:0] own_mass;
    logic        [MW-1:0] peer_mass;
    logic        [BW-1:0] own_bounce;
    logic        [BW-1:0] peer_bounce;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic        [TB:0]   contact_time;
    logic        [1:0]    hit_side;
    logic signed [CW-1:0] own_new_vx;
    logic signed [CW-1:0] own_new_vy;
    logic signed [CW-1:0] peer_new_vx;
    logic signed [CW-1:0] peer_new_vy;
    logic signed [CW-1:0] own_step_x;
    logic signed [CW-1:0] own_step_y;
    logic signed [CW-1:0] peer_step_x;
    logic signed [CW-1:0] peer_step_y;
  } out_t;

  // Clamp to the signed coordinate range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    logic same;
    same = (&v[SAT_W-1:CW-1]) || (~|v[SAT_W-1:CW-1]);
    if (same) begin
      return v[CW-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

@@ src/sbcr_stream_if.sv @@
// Valid/ready stream channel carrying one payload item.
`default_nettype none

interface sbcr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/swept_box_collision_response.sv @@
// Pipelined swept box collision test with restitution impulse response.
//
//   channel   dir  handshake        payload
//   in_i      in   valid/ready      in_t box pair
//   out_o     out  valid/ready      out_t contact and response
//   apb       in   psel/penable     time_step at byte address 0
//
// One item per cycle is sustained while out_o is ready.
// The depth is set by four parallel 16-stage restoring dividers (one quotient
// bit per stage) for the edge crossing times, with a fifth for the mass share.
// Each full stage holds when the stage after it is full and stalled, so bubbles
// collapse and input is taken while any stage is empty.
// Reset clears all stage valid bits and sets time_step to 1092.
`default_nettype none

module swept_box_collision_response
  import sbcr_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sbcr_stream_if.sink        in_i,
  sbcr_stream_if.source      out_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);

  // Stage numbering
  localparam int P_IN   = 0;
  localparam int P_RV   = 1;
  localparam int P_MV   = 2;
  localparam int P_SET  = 3;
  localparam int P_DIV0 = 4;
  localparam int P_PRJ  = P_DIV0 + TB;
  localparam int P_CHK  = P_PRJ + 1;
  localparam int P_SEL  = P_CHK + 1;
  localparam int P_IMP  = P_SEL + 1;
  localparam int P_DV   = P_IMP + 1;
  localparam int P_OUT  = P_DV + 1;
  localparam int NS     = P_OUT + 1;

  // Multiplier product widths
  localparam int MVP_W = RV_W + DTW + 1;
  localparam int OMP_W = CW + DTW + 1;
  localparam int PPP_W = MV_W + TB + 1;
  localparam int DP_W  = NV_W + KW + 1;
  localparam int SP_W  = OM_W + TB + 2;
  localparam int DVP_W = D_W + TB + 2;

  typedef struct packed {
    logic                    pre;
    logic                    ok;
    logic        [CE_W-1:0]  c_abs;
    logic        [MV_W-1:0]  den;
    logic        [REM_W-1:0] rem;
    logic        [TB-1:0]    q;
    logic signed [MV_W-1:0]  other;
    logic signed [CE_W-1:0]  lo;
    logic signed [CE_W-1:0]  hi;
    logic signed [PP_W-1:0]  p;
  } edge_t;

  typedef struct packed {
    in_t                      in;
    logic        [DTW-1:0]    dt;
    logic signed [RV_W-1:0]   rvx;
    logic signed [RV_W-1:0]   rvy;
    logic signed [CE_W-1:0]   x1;
    logic signed [CE_W-1:0]   y1;
    logic        [EW-1:0]     e;
    logic        [MW:0]       msum;
    logic                     moving;
    logic signed [MV_W-1:0]   mx;
    logic signed [MV_W-1:0]   my;
    logic signed [OM_W-1:0]   omx;
    logic signed [OM_W-1:0]   omy;
    logic signed [OM_W-1:0]   pmx;
    logic signed [OM_W-1:0]   pmy;
    edge_t       [3:0]        eg;
    logic        [MREM_W-1:0] mrem;
    logic        [TB-1:0]     mq;
    logic        [TB:0]       f1;
    logic        [TB:0]       f2;
    logic signed [NV_W-1:0]   nv;
    logic signed [D_W-1:0]    d;
    logic signed [DV_W-1:0]   dv1;
    logic signed [DV_W-1:0]   dv2;
    out_t                     res;
  } item_t;

  item_t          st_q [NS];
  item_t          st_d [NS];
  logic [NS-1:0]  vld_q;
  logic [NS-1:0]  en;
  logic [DTW-1:0] dt_q;
  logic           cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TIME_STEP);
  assign prdata = (paddr[2] == REG_TIME_STEP) ? 32'(dt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= DTW'(DT_RESET);
    end else if (cfg_wr) begin
      dt_q <= pwdata[DTW-1:0];
    end
  end

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS-1] = out_o.ready || !vld_q[NS-1];
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = en[k+1] || !vld_q[k];
    end
  end

  assign in_i.ready  = en[P_IN];
  assign out_o.valid = vld_q[P_OUT];
  assign out_o.data  = st_q[P_OUT].res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[P_IN]) begin
        vld_q[P_IN] <= in_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        st_q[g] <= st_d[g];
      end
    end
  end

  // Capture
  always_comb begin
    st_d[P_IN]    = '0;
    st_d[P_IN].in = in_i.data;
    st_d[P_IN].dt = dt_q;
  end

  // Relative velocity, far box corner, restitution, mass sum
  always_comb begin
    logic [2*BW-1:0] bb;
    st_d[P_RV] = st_q[P_RV-1];
    st_d[P_RV].rvx = RV_W'(st_q[P_RV-1].in.own_vel_x) - RV_W'(st_q[P_RV-1].in.peer_vel_x);
    st_d[P_RV].rvy = RV_W'(st_q[P_RV-1].in.own_vel_y) - RV_W'(st_q[P_RV-1].in.peer_vel_y);
    st_d[P_RV].x1  = CE_W'(st_q[P_RV-1].in.rel_min_x) + CE_W'(st_q[P_RV-1].in.rel_width);
    st_d[P_RV].y1  = CE_W'(st_q[P_RV-1].in.rel_min_y) + CE_W'(st_q[P_RV-1].in.rel_height);
    bb = (2*BW)'(st_q[P_RV-1].in.own_bounce) * (2*BW)'(st_q[P_RV-1].in.peer_bounce);
    st_d[P_RV].e    = bb[2*BW-1:TB];
    st_d[P_RV].msum = (MW+1)'(st_q[P_RV-1].in.own_mass) + (MW+1)'(st_q[P_RV-1].in.peer_mass);
    st_d[P_RV].moving = (st_q[P_RV-1].in.own_vel_x != '0) || (st_q[P_RV-1].in.own_vel_y != '0);
  end

  // Moves over one step
  always_comb begin
    logic signed [DTW:0] sdt;
    st_d[P_MV] = st_q[P_MV-1];
    sdt = $signed({1'b0, st_q[P_MV-1].dt});
    st_d[P_MV].mx  = MV_W'((MVP_W'(st_q[P_MV-1].rvx) * MVP_W'(sdt)) >>> FB);
    st_d[P_MV].my  = MV_W'((MVP_W'(st_q[P_MV-1].rvy) * MVP_W'(sdt)) >>> FB);
    st_d[P_MV].omx = OM_W'((OMP_W'(st_q[P_MV-1].in.own_vel_x) * OMP_W'(sdt)) >>> FB);
    st_d[P_MV].omy = OM_W'((OMP_W'(st_q[P_MV-1].in.own_vel_y) * OMP_W'(sdt)) >>> FB);
    st_d[P_MV].pmx = OM_W'((OMP_W'(st_q[P_MV-1].in.peer_vel_x) * OMP_W'(sdt)) >>> FB);
    st_d[P_MV].pmy = OM_W'((OMP_W'(st_q[P_MV-1].in.peer_vel_y) * OMP_W'(sdt)) >>> FB);
  end

  // Edge setup: range test and divider operands
  always_comb begin
    logic signed [CE_W-1:0] c;
    logic signed [MV_W-1:0] cm;
    logic signed [MV_W-1:0] m;
    logic                   flat;
    logic                   inr;
    st_d[P_SET] = st_q[P_SET-1];
    for (int k = 0; k < 4; k++) begin
      unique case (2'(k))
        SIDE_LEFT: begin
          c = CE_W'(st_q[P_SET-1].in.rel_min_x);
          m = st_q[P_SET-1].mx;
          st_d[P_SET].eg[k].other = st_q[P_SET-1].my;
          st_d[P_SET].eg[k].lo = CE_W'(st_q[P_SET-1].in.rel_min_y);
          st_d[P_SET].eg[k].hi = st_q[P_SET-1].y1;
          flat = (st_q[P_SET-1].in.rel_height == '0);
        end
        SIDE_TOP: begin
          c = st_q[P_SET-1].y1;
          m = st_q[P_SET-1].my;
          st_d[P_SET].eg[k].other = st_q[P_SET-1].mx;
          st_d[P_SET].eg[k].lo = CE_W'(st_q[P_SET-1].in.rel_min_x);
          st_d[P_SET].eg[k].hi = st_q[P_SET-1].x1;
          flat = (st_q[P_SET-1].in.rel_width == '0);
        end
        SIDE_RIGHT: begin
          c = st_q[P_SET-1].x1;
          m = st_q[P_SET-1].mx;
          st_d[P_SET].eg[k].other = st_q[P_SET-1].my;
          st_d[P_SET].eg[k].lo = CE_W'(st_q[P_SET-1].in.rel_min_y);
          st_d[P_SET].eg[k].hi = st_q[P_SET-1].y1;
          flat = (st_q[P_SET-1].in.rel_height == '0);
        end
        SIDE_BOTTOM: begin
          c = CE_W'(st_q[P_SET-1].in.rel_min_y);
          m = st_q[P_SET-1].my;
          st_d[P_SET].eg[k].other = st_q[P_SET-1].mx;
          st_d[P_SET].eg[k].lo = CE_W'(st_q[P_SET-1].in.rel_min_x);
          st_d[P_SET].eg[k].hi = st_q[P_SET-1].x1;
          flat = (st_q[P_SET-1].in.rel_width == '0);
        end
      endcase
      cm  = MV_W'(c);
      inr = (m > 0) ? (cm >= 0 && cm < m) : (cm <= 0 && cm > m);
      st_d[P_SET].eg[k].pre   = st_q[P_SET-1].moving && (m != 0) && !flat && inr;
      st_d[P_SET].eg[k].c_abs = (c < 0) ? CE_W'(-c) : CE_W'(c);
      st_d[P_SET].eg[k].den   = (m < 0) ? MV_W'(-m) : MV_W'(m);
      st_d[P_SET].eg[k].rem   = REM_W'(st_d[P_SET].eg[k].c_abs);
      st_d[P_SET].eg[k].q     = '0;
    end
    st_d[P_SET].mrem = MREM_W'(st_q[P_SET-1].in.own_mass);
    st_d[P_SET].mq   = '0;
  end

  // Restoring division, one quotient bit per stage
  for (genvar g = 0; g < TB; g++) begin : g_div
    always_comb begin
      logic [REM_W-1:0]  r2;
      logic [MREM_W-1:0] mr2;
      st_d[P_DIV0+g] = st_q[P_DIV0+g-1];
      for (int k = 0; k < 4; k++) begin
        r2 = {st_q[P_DIV0+g-1].eg[k].rem[REM_W-2:0], 1'b0};
        if (r2 >= REM_W'(st_q[P_DIV0+g-1].eg[k].den)) begin
          st_d[P_DIV0+g].eg[k].rem = r2 - REM_W'(st_q[P_DIV0+g-1].eg[k].den);
          st_d[P_DIV0+g].eg[k].q   = {st_q[P_DIV0+g-1].eg[k].q[TB-2:0], 1'b1};
        end else begin
          st_d[P_DIV0+g].eg[k].rem = r2;
          st_d[P_DIV0+g].eg[k].q   = {st_q[P_DIV0+g-1].eg[k].q[TB-2:0], 1'b0};
        end
      end
      mr2 = {st_q[P_DIV0+g-1].mrem[MREM_W-2:0], 1'b0};
      if (mr2 >= MREM_W'(st_q[P_DIV0+g-1].msum)) begin
        st_d[P_DIV0+g].mrem = mr2 - MREM_W'(st_q[P_DIV0+g-1].msum);
        st_d[P_DIV0+g].mq   = {st_q[P_DIV0+g-1].mq[TB-2:0], 1'b1};
      end else begin
        st_d[P_DIV0+g].mrem = mr2;
        st_d[P_DIV0+g].mq   = {st_q[P_DIV0+g-1].mq[TB-2:0], 1'b0};
      end
    end
  end

  // Crossing points and mass shares
  always_comb begin
    st_d[P_PRJ] = st_q[P_PRJ-1];
    for (int k = 0; k < 4; k++) begin
      st_d[P_PRJ].eg[k].p = PP_W'((PPP_W'(st_q[P_PRJ-1].eg[k].other) *
                                   PPP_W'($signed({1'b0, st_q[P_PRJ-1].eg[k].q}))) >>> TB);
    end
    // An immovable peer takes no share; the peer share is the complement,
    // one lower when the own share was rounded down
    if (st_q[P_PRJ-1].in.peer_mass == '0) begin
      st_d[P_PRJ].f1 = TIME_ONE;
      st_d[P_PRJ].f2 = '0;
    end else begin
      st_d[P_PRJ].f1 = {1'b0, st_q[P_PRJ-1].mq};
      st_d[P_PRJ].f2 = TIME_ONE - {1'b0, st_q[P_PRJ-1].mq}
                       - (TB+1)'(st_q[P_PRJ-1].mrem != '0);
    end
  end

  // Crossing point within the edge
  always_comb begin
    st_d[P_CHK] = st_q[P_CHK-1];
    for (int k = 0; k < 4; k++) begin
      st_d[P_CHK].eg[k].ok = st_q[P_CHK-1].eg[k].pre &&
                             (st_q[P_CHK-1].eg[k].p >= PP_W'(st_q[P_CHK-1].eg[k].lo)) &&
                             (st_q[P_CHK-1].eg[k].p <= PP_W'(st_q[P_CHK-1].eg[k].hi));
    end
  end

  // Earliest edge, lower side wins a tie; approach test
  always_comb begin
    logic                   found;
    logic [TB-1:0]          bt;
    logic [1:0]             bs;
    logic signed [NV_W-1:0] nv;
    st_d[P_SEL] = st_q[P_SEL-1];
    found = 1'b0;
    bt    = '0;
    bs    = SIDE_LEFT;
    for (int k = 0; k < 4; k++) begin
      if (st_q[P_SEL-1].eg[k].ok && (!found || st_q[P_SEL-1].eg[k].q < bt)) begin
        found = 1'b1;
        bt    = st_q[P_SEL-1].eg[k].q;
        bs    = 2'(k);
      end
    end
    unique case (bs)
      SIDE_LEFT:   nv = NV_W'(st_q[P_SEL-1].rvx);
      SIDE_RIGHT:  nv = -NV_W'(st_q[P_SEL-1].rvx);
      SIDE_TOP:    nv = -NV_W'(st_q[P_SEL-1].rvy);
      SIDE_BOTTOM: nv = NV_W'(st_q[P_SEL-1].rvy);
    endcase
    st_d[P_SEL].nv = nv;
    st_d[P_SEL].res.hit = found && (nv > 0);
    st_d[P_SEL].res.contact_time = (found && (nv > 0)) ? {1'b0, bt} : TIME_ONE;
    st_d[P_SEL].res.hit_side     = (found && (nv > 0)) ? bs : SIDE_LEFT;
  end

  // Impulse magnitude and advances up to contact
  always_comb begin
    logic signed [TB+1:0] st;
    logic signed [KW:0]   kf;
    st_d[P_IMP] = st_q[P_IMP-1];
    st = $signed({1'b0, st_q[P_IMP-1].res.contact_time});
    kf = $signed({1'b0, KW'(TIME_ONE) + KW'(st_q[P_IMP-1].e)});
    st_d[P_IMP].d = D_W'((DP_W'(st_q[P_IMP-1].nv) * DP_W'(kf)) >>> TB);
    st_d[P_IMP].res.own_step_x  =
      sat_coord(SAT_W'((SP_W'(st_q[P_IMP-1].omx) * SP_W'(st)) >>> TB));
    st_d[P_IMP].res.own_step_y  =
      sat_coord(SAT_W'((SP_W'(st_q[P_IMP-1].omy) * SP_W'(st)) >>> TB));
    st_d[P_IMP].res.peer_step_x =
      sat_coord(SAT_W'((SP_W'(st_q[P_IMP-1].pmx) * SP_W'(st)) >>> TB));
    st_d[P_IMP].res.peer_step_y =
      sat_coord(SAT_W'((SP_W'(st_q[P_IMP-1].pmy) * SP_W'(st)) >>> TB));
  end

  // Velocity changes from mass shares
  always_comb begin
    st_d[P_DV] = st_q[P_DV-1];
    st_d[P_DV].dv1 = DV_W'((DVP_W'(st_q[P_DV-1].d) *
                            DVP_W'($signed({1'b0, st_q[P_DV-1].f1}))) >>> TB);
    st_d[P_DV].dv2 = DV_W'((DVP_W'(st_q[P_DV-1].d) *
                            DVP_W'($signed({1'b0, st_q[P_DV-1].f2}))) >>> TB);
  end

  // New velocities along the hit normal
  always_comb begin
    logic signed [SAT_W-1:0] ovx, ovy, pvx, pvy, d1, d2;
    st_d[P_OUT] = st_q[P_OUT-1];
    ovx = SAT_W'(st_q[P_OUT-1].in.own_vel_x);
    ovy = SAT_W'(st_q[P_OUT-1].in.own_vel_y);
    pvx = SAT_W'(st_q[P_OUT-1].in.peer_vel_x);
    pvy = SAT_W'(st_q[P_OUT-1].in.peer_vel_y);
    d1  = SAT_W'(st_q[P_OUT-1].dv1);
    d2  = SAT_W'(st_q[P_OUT-1].dv2);
    if (st_q[P_OUT-1].res.hit) begin
      unique case (st_q[P_OUT-1].res.hit_side)
        SIDE_LEFT: begin
          ovx = ovx - d1;
          pvx = pvx + d2;
        end
        SIDE_RIGHT: begin
          ovx = ovx + d1;
          pvx = pvx - d2;
        end
        SIDE_TOP: begin
          ovy = ovy + d1;
          pvy = pvy - d2;
        end
        SIDE_BOTTOM: begin
          ovy = ovy - d1;
          pvy = pvy + d2;
        end
      endcase
    end
    st_d[P_OUT].res.own_new_vx  = sat_coord(ovx);
    st_d[P_OUT].res.own_new_vy  = sat_coord(ovy);
    st_d[P_OUT].res.peer_new_vx = sat_coord(pvx);
    st_d[P_OUT].res.peer_new_vy = sat_coord(pvy);
  end

  // Checks
  a_hit_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[P_OUT] && st_q[P_OUT].res.hit) |-> (st_q[P_OUT].res.contact_time < TIME_ONE))
    else $error("hit with full-step contact time");

  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[P_OUT] && !st_q[P_OUT].res.hit) |->
      (st_q[P_OUT].res.contact_time == TIME_ONE && st_q[P_OUT].res.hit_side == SIDE_LEFT))
    else $error("miss with contact time or side set");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q))
    else $error("input stalled while a stage is empty");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (dt_q == $past(pwdata[DTW-1:0])))
    else $error("time step write lost");

endmodule

`default_nettype wire

@@ tb/sv/sbcr_checker.sv @@
// Scoreboard for the swept box collision block: predicts each result and compares it.
module sbcr_checker
  import sbcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sbcr_stream_if      in_ch,
  sbcr_stream_if      out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count,
  output int          hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  out_t            contact_q[$];
  logic [DTW-1:0]  step_reg;

  // Clamp a wide value into the signed coordinate range
  function automatic logic signed [CW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[CW-1:0];
  endfunction

  // Crossing test of one edge line c by move component m
  function automatic bit edge_hit(longint c, longint m, longint other, longint lo,
                                  longint hi, output longint t);
    longint p;
    longint ac;
    longint am;
    t = 0;
    if (m == 0 || hi == lo) return 0;
    if (m > 0) begin
      if (c < 0 || c >= m) return 0;
    end else begin
      if (c > 0 || c <= m) return 0;
    end
    ac = (c < 0) ? -c : c;
    am = (m < 0) ? -m : m;
    t = (ac <<< TB) / am;
    p = (other * t) >>> TB;
    if (p < lo || p > hi) return 0;
    return 1;
  endfunction

  // Contact and impulse response of one box pair
  function automatic out_t predict_contact(in_t a, longint dt);
    out_t   r;
    longint x0, y0, x1, y1, ovx, ovy, pvx, pvy, m1, m2, b1, b2;
    longint rvx, rvy, mx, my, t, best_t, cand, nx, ny, vdn, e, d, f1, f2, dv1, dv2;
    int     best;
    bit     ok;
    x0  = a.rel_min_x;
    y0  = a.rel_min_y;
    x1  = x0 + longint'(a.rel_width);
    y1  = y0 + longint'(a.rel_height);
    ovx = a.own_vel_x;
    ovy = a.own_vel_y;
    pvx = a.peer_vel_x;
    pvy = a.peer_vel_y;
    m1  = longint'(a.own_mass);
    m2  = longint'(a.peer_mass);
    b1  = longint'(a.own_bounce);
    b2  = longint'(a.peer_bounce);
    rvx = ovx - pvx;
    rvy = ovy - pvy;
    mx  = (rvx * dt) >>> FB;
    my  = (rvy * dt) >>> FB;
    t = 65536;
    best_t = 0;
    best = -1;
    // Sweep every edge; a strict compare keeps the lower side on ties
    if (ovx != 0 || ovy != 0) begin
      for (int i = 0; i < 4; i++) begin
        case (i)
          0:       ok = edge_hit(x0, mx, my, y0, y1, cand);
          1:       ok = edge_hit(y1, my, mx, x0, x1, cand);
          2:       ok = edge_hit(x1, mx, my, y0, y1, cand);
          default: ok = edge_hit(y0, my, mx, x0, x1, cand);
        endcase
        if (ok && (best < 0 || cand < best_t)) begin
          best = i;
          best_t = cand;
        end
      end
    end
    r = '0;
    r.own_new_vx  = clamp32(ovx);
    r.own_new_vy  = clamp32(ovy);
    r.peer_new_vx = clamp32(pvx);
    r.peer_new_vy = clamp32(pvy);
    if (best >= 0) begin
      nx  = (best == 0) ? -1 : ((best == 2) ? 1 : 0);
      ny  = (best == 1) ? 1 : ((best == 3) ? -1 : 0);
      vdn = rvx * nx + rvy * ny;
      // Only an approaching contact gets the impulse
      if (vdn < 0) begin
        e = (b1 * b2) >>> TB;
        d = ((65536 + e) * (-vdn)) >>> TB;
        if (m2 == 0) begin
          f1 = 65536;
          f2 = 0;
        end else begin
          f1 = (m1 <<< TB) / (m1 + m2);
          f2 = (m2 <<< TB) / (m1 + m2);
        end
        dv1 = (d * f1) >>> TB;
        dv2 = (d * f2) >>> TB;
        r.hit = 1'b1;
        r.hit_side = best[1:0];
        t = best_t;
        r.own_new_vx  = clamp32(ovx + nx * dv1);
        r.own_new_vy  = clamp32(ovy + ny * dv1);
        r.peer_new_vx = clamp32(pvx - nx * dv2);
        r.peer_new_vy = clamp32(pvy - ny * dv2);
      end
    end
    r.contact_time = t[TB:0];
    r.own_step_x  = clamp32((((ovx * dt) >>> FB) * t) >>> TB);
    r.own_step_y  = clamp32((((ovy * dt) >>> FB) * t) >>> TB);
    r.peer_step_x = clamp32((((pvx * dt) >>> FB) * t) >>> TB);
    r.peer_step_y = clamp32((((pvy * dt) >>> FB) * t) >>> TB);
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    hit_count = 0;
    step_reg = DTW'(DT_RESET);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      step_reg <= DTW'(DT_RESET);
    end else begin
      // Track time step writes
      if (psel && penable && pwrite && pready && paddr == 3'd0) begin
        step_reg <= pwdata[DTW-1:0];
      end
      // Compare a delivered result
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (contact_q.size() == 0) begin
          $display("%0t: unexpected result, nothing pending", $time);
          fail_count++;
        end else begin
          want = contact_q.pop_front();
          if (want.hit) hit_count++;
          check_field("hit", want.hit, got.hit);
          check_field("contact_time", want.contact_time, got.contact_time);
          check_field("hit_side", want.hit_side, got.hit_side);
          check_field("own_new_vx", want.own_new_vx, got.own_new_vx);
          check_field("own_new_vy", want.own_new_vy, got.own_new_vy);
          check_field("peer_new_vx", want.peer_new_vx, got.peer_new_vx);
          check_field("peer_new_vy", want.peer_new_vy, got.peer_new_vy);
          check_field("own_step_x", want.own_step_x, got.own_step_x);
          check_field("own_step_y", want.own_step_y, got.own_step_y);
          check_field("peer_step_x", want.peer_step_x, got.peer_step_x);
          check_field("peer_step_y", want.peer_step_y, got.peer_step_y);
        end
      end
      // Predict each accepted box pair
      if (in_ch.valid && in_ch.ready) begin
        contact_q = {contact_q, predict_contact(in_ch.data, longint'(step_reg))};
      end
      pending_count <= contact_q.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the swept box collision testbench: clock, reset, stimulus and verdict.
module testbench
  import sbcr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;
  int          fail_count, pending_count, hit_count;
  int          sent_count;
  bit          calm;

  sbcr_stream_if #(.T(in_t))  in_ch ();
  sbcr_stream_if #(.T(out_t)) out_ch ();

  swept_box_collision_response dut (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_ch), .out_o(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sbcr_checker scoreboard (
    .clk_i(clk), .rst_ni(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
    .pending_count(pending_count), .hit_count(hit_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side stalls at random
  always @(posedge clk) begin
    out_ch.ready <= rst_n && (calm || ($urandom_range(0, 99) >= 32));
  end

  initial begin
    #3ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic in_t make_pair(longint x0, longint y0, longint w, longint h,
                                    longint ovx, longint ovy, longint pvx, longint pvy,
                                    longint m1, longint m2, longint b1, longint b2);
    in_t a;
    a.rel_min_x = x0[CW-1:0];
    a.rel_min_y = y0[CW-1:0];
    a.rel_width = w[MW-1:0];
    a.rel_height = h[MW-1:0];
    a.own_vel_x = ovx[CW-1:0];
    a.own_vel_y = ovy[CW-1:0];
    a.peer_vel_x = pvx[CW-1:0];
    a.peer_vel_y = pvy[CW-1:0];
    a.own_mass = m1[MW-1:0];
    a.peer_mass = m2[MW-1:0];
    a.own_bounce = b1[BW-1:0];
    a.peer_bounce = b2[BW-1:0];
    return a;
  endfunction

  // Offer one item, with an optional random gap first
  task automatic send_pair(in_t a);
    if (!calm && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 50);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= a;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sent_count++;
  endtask

  // Wait for every pending result, then let the pipeline empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_step(logic [31:0] v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Random pair: mostly a box near the origin reachable in one step, some pure noise
  function automatic in_t random_pair(int vel_span);
    longint m2;
    if ($urandom_range(0, 99) < 20) begin
      return make_pair($signed($urandom), $signed($urandom), $urandom, $urandom,
                       $signed($urandom), $signed($urandom), $signed($urandom),
                       $signed($urandom), $urandom_range(1, 32'h7fffffff), $urandom,
                       $urandom_range(0, 131071), $urandom_range(0, 131071));
    end
    m2 = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 32'h100000);
    return make_pair(longint'($urandom_range(0, 32'h60000)) - 32'h30000,
                     longint'($urandom_range(0, 32'h60000)) - 32'h30000,
                     $urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000),
                     longint'($urandom_range(0, 2 * vel_span)) - vel_span,
                     longint'($urandom_range(0, 2 * vel_span)) - vel_span,
                     longint'($urandom_range(0, vel_span)) - vel_span / 2,
                     longint'($urandom_range(0, vel_span)) - vel_span / 2,
                     $urandom_range(1, 32'h100000), m2,
                     $urandom_range(0, 65536), $urandom_range(0, 65536));
  endfunction

  task automatic random_phase(int count, int vel_span);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 3 + 40);
      if (i == count / 2) drain();
      send_pair(random_pair(vel_span));
    end
    calm = 0;
  endtask

  localparam longint ONE = 32'h10000;
  localparam longint MAXV = 32'h7fffffff;
  localparam longint MINV = -64'sh80000000;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    calm = 0;
    sent_count = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset time step, a few pairs
    random_phase(30, 32'h3000000);

    // Directed pairs at a one-second step
    write_step(32'h10000);
    send_pair(make_pair(ONE / 2, -ONE, 2 * ONE, 2 * ONE, ONE, 0, 0, 0, ONE, ONE, 65536, 65536));
    send_pair(make_pair(-ONE, -5 * ONE / 2, 2 * ONE, 2 * ONE, 0, -ONE, 0, 0, ONE, 0, 0, 0));
    send_pair(make_pair(-5 * ONE / 2, -ONE, 2 * ONE, 2 * ONE, -ONE, 0, 0, 0, ONE, 3 * ONE,
                        32768, 65536));
    send_pair(make_pair(-ONE, ONE / 2, 2 * ONE, 2 * ONE, 0, ONE, 0, ONE / 4, ONE, ONE,
                        65536, 32768));
    // Own body at rest while the peer moves
    send_pair(make_pair(ONE / 2, -ONE, 2 * ONE, 2 * ONE, 0, 0, -ONE, 0, ONE, ONE, 65536, 65536));
    // Receding contact: inside the box, moving out through the right edge
    send_pair(make_pair(-ONE, -ONE, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0, ONE, ONE, 65536, 65536));
    // Degenerate edges of zero length
    send_pair(make_pair(ONE / 2, -ONE, 0, 0, ONE, ONE / 8, 0, 0, ONE, ONE, 65536, 65536));
    send_pair(make_pair(ONE / 2, -ONE, 2 * ONE, 0, ONE, 0, 0, 0, ONE, ONE, 65536, 65536));
    // Move parallel to an edge
    send_pair(make_pair(-ONE, ONE / 2, 2 * ONE, 2 * ONE, ONE, 0, 0, 0, ONE, ONE, 65536, 65536));
    // Both masses zero, bounce above one
    send_pair(make_pair(ONE / 2, -ONE, 2 * ONE, 2 * ONE, ONE, 0, 0, 0, 0, 0, 131071, 131071));
    // Corner hit: the left and bottom edges are crossed at the same contact time
    send_pair(make_pair(ONE / 2, ONE / 2, 2 * ONE, 2 * ONE, ONE, ONE, 0, 0, ONE, ONE, 65536, 0));
    // Velocity extremes, saturation of the response
    send_pair(make_pair(ONE / 2, -ONE, 2 * ONE, 2 * ONE, MAXV, 0, MINV, 0, 1, MAXV,
                        131071, 131071));
    send_pair(make_pair(-5 * ONE / 2, -ONE, 2 * ONE, 2 * ONE, MINV, MINV, MAXV, MAXV, MAXV, 1,
                        65536, 65536));
    send_pair(make_pair(MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MAXV, MAXV, 131071, 0));
    send_pair(make_pair(MAXV, MAXV, MAXV, MAXV, MINV, MINV, MAXV, MAXV, 1, 0, 0, 131071));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    send_pair(make_pair(-1, -1, 1, 1, 1, -1, 0, 0, 1, 1, 1, 1));

    random_phase(180, 32'h30000);
    // Larger step
    write_step(32'h100000);
    random_phase(120, 32'h4000);
    send_pair(make_pair(ONE / 2, -ONE, 2 * ONE, 2 * ONE, MAXV, 0, MINV, 0, 1, MAXV,
                        131071, 131071));
    // Smallest nonzero step
    write_step(32'h1);
    random_phase(80, 32'h7fffffff);
    // Zero step gives no move at all
    write_step(32'h0);
    random_phase(20, 32'h30000);
    write_step(32'h4000);
    random_phase(220, 32'h100000);

    drain();
    $display("covered %0d box pairs over six time steps, %0d approaching contacts",
             sent_count, hit_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
